// ===== src/ggba_pkg.sv =====
// shared types, constants and sizes of the 3d grid binning accumulator
package ggba_pkg;

  localparam int unsigned GRID_X     = 16;
  localparam int unsigned GRID_Y     = 16;
  localparam int unsigned GRID_Z     = 16;
  localparam int unsigned CELL_TOTAL = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned CELL_AW    = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int unsigned PLANE_YZ   = GRID_Y * GRID_Z;

  localparam int unsigned SUM_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CELL_W = SUM_W + CNT_W;
  localparam int unsigned PADDR_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_CPU_X   = 3'd3,
    REG_CPU_Y   = 3'd4,
    REG_CPU_Z   = 3'd5,
    REG_NORM    = 3'd6,
    REG_SPARE   = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MISS  = 3'd1,
    OP_READ  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_NOP   = 3'd4
  } op_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] intensity;
    logic [11:0]        cell_select;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] cell_value;
    logic [31:0]        cell_hits;
    logic [31:0]        outside_total;
    logic               landed;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [31:0]        cpu_x;
    logic [31:0]        cpu_y;
    logic [31:0]        cpu_z;
    logic               norm_mode;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [CELL_AW-1:0] pos;
    logic signed [31:0] intensity;
  } job_t;

endpackage

// ===== src/ggba_ram.sv =====
// generic simple dual port ram with registered read
module ggba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/ggba_fifo.sv =====
// two entry job queue between front and back
module ggba_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ggba_pkg::job_t  push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ggba_pkg::job_t  head_o
);
  import ggba_pkg::*;

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== src/ggba_front.sv =====
// front end: takes words, works out the grid cell and queues a job
module ggba_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ggba_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ggba_pkg::in_word_t  in_word_i,
  input  logic                full_i,
  output logic                push_o,
  output ggba_pkg::job_t      job_o
);
  import ggba_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e            state_q, state_d;
  logic [1:0]         cmd_q;
  logic signed [31:0] int_q;
  logic [11:0]        sel_q;
  logic signed [32:0] off_q [3];
  logic [64:0]        prod_q [3];
  logic [2:0]         neg_q;
  logic               accept;
  logic [2:0]         in_grid;
  logic [31:0]        idx [3];
  logic [31:0]        pos32;
  logic [31:0]        sel32;
  logic [31:0]        grid [3];
  logic [31:0]        cpu [3];

  assign grid[0] = GRID_X;
  assign grid[1] = GRID_Y;
  assign grid[2] = GRID_Z;
  assign cpu[0]  = cfg_i.cpu_x;
  assign cpu[1]  = cfg_i.cpu_y;
  assign cpu[2]  = cfg_i.cpu_z;

  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign in_stall_o = !((state_q == F_IDLE) || push_o);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept) state_d = F_MUL;
      F_MUL:   state_d = F_PUSH;
      F_PUSH:  if (push_o) state_d = accept ? F_MUL : F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // offsets on accept, products in the F_MUL state that follows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_word_i.cmd;
      int_q    <= in_word_i.intensity;
      sel_q    <= in_word_i.cell_select;
      off_q[0] <= {in_word_i.coord_x[31], in_word_i.coord_x}
                  - {cfg_i.start_x[31], cfg_i.start_x};
      off_q[1] <= {in_word_i.coord_y[31], in_word_i.coord_y}
                  - {cfg_i.start_y[31], cfg_i.start_y};
      off_q[2] <= {in_word_i.coord_z[31], in_word_i.coord_z}
                  - {cfg_i.start_z[31], cfg_i.start_z};
    end
    if (state_q == F_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= {32'd0, off_q[i]} * {33'd0, cpu[i]};
        neg_q[i]  <= off_q[i][32];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_grid[i] = !neg_q[i] && (prod_q[i][64:32] < {1'b0, grid[i]});
      idx[i]     = prod_q[i][63:32];
    end
    pos32 = idx[0] * PLANE_YZ + idx[1] * GRID_Z + idx[2];
    sel32 = {20'd0, sel_q};

    job_o.intensity = int_q;
    job_o.pos       = pos32[CELL_AW-1:0];
    job_o.op        = OP_NOP;
    unique case (cmd_q)
      CMD_ADD:   job_o.op = (&in_grid) ? OP_ADD : OP_MISS;
      CMD_READ:  begin
        job_o.op  = (sel32 < CELL_TOTAL) ? OP_READ : OP_NOP;
        job_o.pos = sel32[CELL_AW-1:0];
      end
      CMD_CLEAR: job_o.op = OP_CLEAR;
      default:   job_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== src/ggba_back.sv =====
// back end: cell read-modify-write, mean divider, clearing sweep, result register
module ggba_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 norm_mode_i,
  input  logic                 valid_i,
  input  ggba_pkg::job_t       job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ggba_pkg::out_word_t  out_word_o
);
  import ggba_pkg::*;

  typedef enum logic [3:0] {
    B_CLR  = 4'b0001,
    B_IDLE = 4'b0010,
    B_RD   = 4'b0100,
    B_DIV  = 4'b1000
  } bstate_e;

  bstate_e            state_q, state_d;
  job_t               cur_q;
  logic [CELL_AW-1:0] clr_q;
  logic               report_q;
  logic [CNT_W-1:0]   outside_q, outside_d;
  logic [SUM_W-1:0]   quo_q;
  logic [CNT_W:0]     rem_q;
  logic [CNT_W-1:0]   den_q;
  logic               neg_q;
  logic [5:0]         step_q;
  logic               out_valid_q;
  out_word_t          out_q, out_d;
  logic               load;
  logic               out_free;

  logic               we;
  logic [CELL_AW-1:0] waddr, raddr;
  logic [CELL_W-1:0]  wdata, rdata;
  logic [SUM_W-1:0]   rd_sum, add_sum, sat_sum, ext_int, mag;
  logic [CNT_W-1:0]   rd_cnt, inc_cnt;
  logic [CNT_W:0]     rem_sh, rem_sub;
  logic               qbit;
  logic [SUM_W-1:0]   quo_next;

  ggba_ram #(.WIDTH(CELL_W), .DEPTH(CELL_TOTAL)) u_cells (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == B_IDLE) && valid_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign raddr       = job_i.pos;

  assign rd_sum  = rdata[CELL_W-1:CNT_W];
  assign rd_cnt  = rdata[CNT_W-1:0];
  assign ext_int = {{(SUM_W-32){cur_q.intensity[31]}}, cur_q.intensity};
  assign add_sum = rd_sum + ext_int;
  assign inc_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  assign mag     = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

  always_comb begin
    sat_sum = add_sum;
    if ((rd_sum[SUM_W-1] == ext_int[SUM_W-1]) && (add_sum[SUM_W-1] != rd_sum[SUM_W-1])) begin
      sat_sum = rd_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
  end

  // one quotient bit per cycle
  assign rem_sh   = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign qbit     = (rem_sh >= {1'b0, den_q});
  assign rem_sub  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_next = {quo_q[SUM_W-2:0], qbit};

  always_comb begin
    state_d   = state_q;
    outside_d = outside_q;
    load      = 1'b0;
    out_d     = '0;
    we        = 1'b0;
    waddr     = cur_q.pos;
    wdata     = {sat_sum, inc_cnt};
    unique case (state_q)
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        if (clr_q == CELL_AW'(CELL_TOTAL - 1)) begin
          state_d = B_IDLE;
          load    = report_q;
        end
      end
      B_IDLE: begin
        if (pop_o) begin
          unique case (job_i.op)
            OP_ADD, OP_READ: state_d = B_RD;
            OP_MISS: begin
              if (outside_q != CNT_MAX) outside_d = outside_q + 1'b1;
              load = 1'b1;
              out_d.outside_total = outside_d;
            end
            OP_CLEAR: begin
              outside_d = '0;
              state_d   = B_CLR;
            end
            default: begin
              load = 1'b1;
              out_d.outside_total = outside_q;
            end
          endcase
        end
      end
      B_RD: begin
        out_d.outside_total = outside_q;
        if (cur_q.op == OP_ADD) begin
          we           = 1'b1;
          load         = 1'b1;
          out_d.landed = 1'b1;
          state_d      = B_IDLE;
        end else if (norm_mode_i && (rd_cnt != '0)) begin
          state_d = B_DIV;
        end else begin
          load             = 1'b1;
          out_d.cell_hits  = rd_cnt;
          out_d.cell_value = norm_mode_i ? '0 : rd_sum;
          state_d          = B_IDLE;
        end
      end
      B_DIV: begin
        if (step_q == 6'd63) begin
          load                = 1'b1;
          out_d.outside_total = outside_q;
          out_d.cell_hits     = den_q;
          out_d.cell_value    = neg_q ? (~quo_next + 1'b1) : quo_next;
          state_d             = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      report_q    <= 1'b0;
      outside_q   <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q   <= state_d;
      outside_q <= outside_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (pop_o && (job_i.op == OP_CLEAR)) begin
        clr_q    <= '0;
        report_q <= 1'b1;
      end
      if (state_q == B_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (load) begin
      out_q <= out_d;
    end
    if (state_q == B_RD) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= rd_cnt;
      neg_q <= rd_sum[SUM_W-1];
    end else if (state_q == B_DIV) begin
      quo_q <= quo_next;
      rem_q <= rem_sub;
    end
  end

endmodule

// ===== src/grid3d_binning_accumulator.sv =====
// top level of the 3d grid binning accumulator: register port, front, queue, back
// clear: one cell zeroed a cycle through the single write port
// the back takes no new job until the cell ram read-modify-write of the last one is done
// reset: registers to defaults, then a clearing pass over all 4096 cells; jobs wait meanwhile
module grid3d_binning_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ggba_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ggba_pkg::out_word_t                 out_word_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ggba_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ggba_pkg::*;

  cfg_t cfg_q;
  reg_e reg_sel;
  logic cfg_wr;
  logic push, full, pop, job_valid;
  job_t push_job, head_job;

  // register file, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x   <= '0;
      cfg_q.start_y   <= '0;
      cfg_q.start_z   <= '0;
      cfg_q.cpu_x     <= 32'd65536;
      cfg_q.cpu_y     <= 32'd65536;
      cfg_q.cpu_z     <= 32'd65536;
      cfg_q.norm_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START_X: cfg_q.start_x   <= pwdata;
        REG_START_Y: cfg_q.start_y   <= pwdata;
        REG_START_Z: cfg_q.start_z   <= pwdata;
        REG_CPU_X:   cfg_q.cpu_x     <= pwdata;
        REG_CPU_Y:   cfg_q.cpu_y     <= pwdata;
        REG_CPU_Z:   cfg_q.cpu_z     <= pwdata;
        REG_NORM:    cfg_q.norm_mode <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_X: prdata = cfg_q.start_x;
      REG_START_Y: prdata = cfg_q.start_y;
      REG_START_Z: prdata = cfg_q.start_z;
      REG_CPU_X:   prdata = cfg_q.cpu_x;
      REG_CPU_Y:   prdata = cfg_q.cpu_y;
      REG_CPU_Z:   prdata = cfg_q.cpu_z;
      REG_NORM:    prdata = {31'd0, cfg_q.norm_mode};
      default:     prdata = '0;
    endcase
  end

  // front: offsets, products, cell index, classification
  ggba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // short queue so front and back stall independently
  ggba_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  // back: cell memory, outside counter, divider, result word register
  ggba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .norm_mode_i (cfg_q.norm_mode),
    .valid_i     (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
